// ----- hdl/yuvlogo_pkg.sv -----
// Shared types and constants for the YUV 4:2:0 logo overlay.
`timescale 1ns / 1ps

package yuvlogo_pkg;

  // Field widths.
  localparam int DIM_W      = 13;  // frame dimensions and window bounds
  localparam int SUM_W      = DIM_W + 1;
  localparam int POS_W      = 12;  // column, row and logo origin
  localparam int PIX_W      = 8;   // samples, logo values and alphas
  localparam int LOGO_DIM_W = 7;   // logo width and height registers
  localparam int WEIGHT_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int BLEND_W    = 2 * PIX_W;

  // Stream payload widths.
  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 8;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
  localparam logic [PIX_W-1:0]    ALPHA_MAX   = 8'd255;

  typedef enum logic [1:0] {
    OP_LOAD_LUMA   = 2'd0,
    OP_LOAD_CHROMA = 2'd1,
    OP_VIDEO       = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_LOGO_X       = 3'd2,
    CFG_LOGO_Y       = 3'd3,
    CFG_LOGO_WIDTH   = 3'd4,
    CFG_LOGO_HEIGHT  = 3'd5,
    CFG_WEIGHT       = 3'd6
  } cfg_reg_e;

  // Logo window bounds in luma and chroma plane coordinates; ends are exclusive.
  typedef struct packed {
    logic             frame_ok;
    logic [DIM_W-1:0] luma_x0;
    logic [DIM_W-1:0] luma_xend;
    logic [DIM_W-1:0] luma_y0;
    logic [DIM_W-1:0] luma_yend;
    logic [DIM_W-1:0] chroma_x0;
    logic [DIM_W-1:0] chroma_xend;
    logic [DIM_W-1:0] chroma_y0;
    logic [DIM_W-1:0] chroma_yend;
  } win_cfg_t;

  // Logo store controls.
  typedef struct packed {
    logic luma_we;
    logic chroma_we;
    logic rd_en;
  } store_ctl_t;

endpackage

// ----- hdl/yuvlogo_cfg.sv -----
// Configuration registers and the derived logo window bounds.
`timescale 1ns / 1ps

module yuvlogo_cfg
  import yuvlogo_pkg::*;
#(
  parameter int MAX_LOGO_W = 64,
  parameter int MAX_LOGO_H = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_index_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output win_cfg_t              win_o,
  output logic [WEIGHT_W-1:0]   weight_o
);

  logic [DIM_W-1:0]      frame_width_q, frame_height_q;
  logic [POS_W-1:0]      logo_x_q, logo_y_q;
  logic [LOGO_DIM_W-1:0] logo_width_q, logo_height_q;
  logic [WEIGHT_W-1:0]   weight_q;

  win_cfg_t            win_d, win_q;
  logic [WEIGHT_W-1:0] weight_sat_d, weight_sat_q;

  logic [DIM_W-1:0] x13, y13, lw, lh_clamp, lh, fh_rem, hl, cw, cox, coy, fwh;
  logic [SUM_W-1:0] xsum, cxsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 13'd1280;
      frame_height_q <= 13'd720;
      logo_x_q       <= '0;
      logo_y_q       <= '0;
      logo_width_q   <= 7'd64;
      logo_height_q  <= 7'd64;
      weight_q       <= WEIGHT_FULL;
    end else if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= wr_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= wr_data_i[DIM_W-1:0];
        CFG_LOGO_X:       logo_x_q       <= wr_data_i[POS_W-1:0];
        CFG_LOGO_Y:       logo_y_q       <= wr_data_i[POS_W-1:0];
        CFG_LOGO_WIDTH:   logo_width_q   <= wr_data_i[LOGO_DIM_W-1:0];
        CFG_LOGO_HEIGHT:  logo_height_q  <= wr_data_i[LOGO_DIM_W-1:0];
        CFG_WEIGHT:       weight_q       <= wr_data_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    x13 = DIM_W'(logo_x_q);
    y13 = DIM_W'(logo_y_q);

    // The logo is limited to the store size and to an even height.
    lw = (DIM_W'(logo_width_q) > DIM_W'(MAX_LOGO_W)) ? DIM_W'(MAX_LOGO_W)
                                                      : DIM_W'(logo_width_q);
    lh_clamp = (DIM_W'(logo_height_q) > DIM_W'(MAX_LOGO_H)) ? DIM_W'(MAX_LOGO_H)
                                                             : DIM_W'(logo_height_q);
    lh = {lh_clamp[DIM_W-1:1], 1'b0};

    // Luma window, clipped at the right and bottom frame edges.
    xsum   = SUM_W'(x13) + SUM_W'(lw);
    fh_rem = frame_height_q - y13;
    hl     = (lh < fh_rem) ? lh : fh_rem;

    // Chroma window at half resolution.
    cw    = DIM_W'(lw + DIM_W'(1)) >> 1;
    cox   = x13 >> 1;
    coy   = y13 >> 1;
    fwh   = frame_width_q >> 1;
    cxsum = SUM_W'(cox) + SUM_W'(cw);

    win_d.frame_ok    = (x13 < frame_width_q) && (y13 < frame_height_q);
    win_d.luma_x0     = x13;
    win_d.luma_xend   = (xsum < SUM_W'(frame_width_q)) ? xsum[DIM_W-1:0] : frame_width_q;
    win_d.luma_y0     = y13;
    win_d.luma_yend   = y13 + hl;
    win_d.chroma_x0   = cox;
    win_d.chroma_xend = (cxsum < SUM_W'(fwh)) ? cxsum[DIM_W-1:0] : fwh;
    win_d.chroma_y0   = coy;
    win_d.chroma_yend = coy + (hl >> 1);

    weight_sat_d = (weight_q > WEIGHT_FULL) ? WEIGHT_FULL : weight_q;
  end

  // Derived bounds follow the registers in the next cycle.
  always_ff @(posedge clk_i) begin
    win_q        <= win_d;
    weight_sat_q <= weight_sat_d;
  end

  assign win_o    = win_q;
  assign weight_o = weight_sat_q;

endmodule

// ----- hdl/yuvlogo_window.sv -----
// Logo window hit test and logo coordinates for one video sample.
`timescale 1ns / 1ps

module yuvlogo_window
  import yuvlogo_pkg::*;
(
  input  win_cfg_t         win_i,
  input  plane_e           plane_i,
  input  logic [POS_W-1:0] column_i,
  input  logic [POS_W-1:0] row_i,
  output logic             inside_o,
  output logic [POS_W-1:0] logo_col_o,
  output logic [POS_W-1:0] logo_row_o
);

  logic             plane_ok;
  logic [DIM_W-1:0] x0, xend, y0, yend, col13, row13, dx, dy;

  always_comb begin
    plane_ok = 1'b1;
    unique case (plane_i)
      PLANE_Y: begin
        x0   = win_i.luma_x0;
        xend = win_i.luma_xend;
        y0   = win_i.luma_y0;
        yend = win_i.luma_yend;
      end
      PLANE_U, PLANE_V: begin
        x0   = win_i.chroma_x0;
        xend = win_i.chroma_xend;
        y0   = win_i.chroma_y0;
        yend = win_i.chroma_yend;
      end
      default: begin
        plane_ok = 1'b0;
        x0       = win_i.luma_x0;
        xend     = win_i.luma_xend;
        y0       = win_i.luma_y0;
        yend     = win_i.luma_yend;
      end
    endcase

    col13 = DIM_W'(column_i);
    row13 = DIM_W'(row_i);
    dx    = col13 - x0;
    dy    = row13 - y0;

    inside_o = win_i.frame_ok && plane_ok &&
               (col13 >= x0) && (col13 < xend) &&
               (row13 >= y0) && (row13 < yend);
    logo_col_o = dx[POS_W-1:0];
    logo_row_o = dy[POS_W-1:0];
  end

endmodule

// ----- hdl/yuvlogo_store.sv -----
// Logo memories: luma value and alpha, chroma U, V and alpha.
`timescale 1ns / 1ps

module yuvlogo_store
  import yuvlogo_pkg::*;
#(
  parameter int LX_W = 6,
  parameter int LY_W = 6,
  parameter int CX_W = 5,
  parameter int CY_W = 5
) (
  input  logic                   clk_i,
  input  store_ctl_t             ctl_i,
  input  logic [LX_W+LY_W-1:0]   luma_waddr_i,
  input  logic [CX_W+CY_W-1:0]   chroma_waddr_i,
  input  logic [PIX_W-1:0]       value_i,
  input  logic [PIX_W-1:0]       value_v_i,
  input  logic [PIX_W-1:0]       alpha_i,
  input  logic [LX_W+LY_W-1:0]   luma_raddr_i,
  input  logic [CX_W+CY_W-1:0]   chroma_raddr_i,
  output logic [2*PIX_W-1:0]     luma_rdata_o,   // value, alpha
  output logic [3*PIX_W-1:0]     chroma_rdata_o  // U, V, alpha
);

  localparam int LUMA_DEPTH   = 1 << (LX_W + LY_W);
  localparam int CHROMA_DEPTH = 1 << (CX_W + CY_W);

  logic [2*PIX_W-1:0] luma_mem_q   [LUMA_DEPTH];
  logic [3*PIX_W-1:0] chroma_mem_q [CHROMA_DEPTH];
  logic [2*PIX_W-1:0] luma_rdata_q;
  logic [3*PIX_W-1:0] chroma_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.luma_we) begin
      luma_mem_q[luma_waddr_i] <= {alpha_i, value_i};
    end
    if (ctl_i.rd_en) begin
      luma_rdata_q <= luma_mem_q[luma_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.chroma_we) begin
      chroma_mem_q[chroma_waddr_i] <= {alpha_i, value_v_i, value_i};
    end
    if (ctl_i.rd_en) begin
      chroma_rdata_q <= chroma_mem_q[chroma_raddr_i];
    end
  end

  assign luma_rdata_o   = luma_rdata_q;
  assign chroma_rdata_o = chroma_rdata_q;

endmodule

// ----- hdl/yuvlogo_mix.sv -----
// Alpha scaling and blend stages with the output register.
`timescale 1ns / 1ps

module yuvlogo_mix
  import yuvlogo_pkg::*;
(
  input  logic                clk_i,
  input  logic                en3_i,
  input  logic                en4_i,
  input  plane_e              plane_i,
  input  logic                inside_i,
  input  logic [PIX_W-1:0]    sample_i,
  input  logic [2*PIX_W-1:0]  luma_word_i,
  input  logic [3*PIX_W-1:0]  chroma_word_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic [PIX_W-1:0]    sample_o,
  output logic                blended_o
);

  logic [PIX_W-1:0]   value, alpha;
  logic [BLEND_W-1:0] alpha_prod, blend_sum;
  logic               hit;

  logic [PIX_W-1:0] val_q, a_q, smp_q, out_q;
  logic             hit_q, blended_q;

  // Stage 2: pick the logo entry of the plane and scale its alpha.
  always_comb begin
    unique case (plane_i)
      PLANE_U: begin
        value = chroma_word_i[PIX_W-1:0];
        alpha = chroma_word_i[3*PIX_W-1:2*PIX_W];
      end
      PLANE_V: begin
        value = chroma_word_i[2*PIX_W-1:PIX_W];
        alpha = chroma_word_i[3*PIX_W-1:2*PIX_W];
      end
      default: begin
        value = luma_word_i[PIX_W-1:0];
        alpha = luma_word_i[2*PIX_W-1:PIX_W];
      end
    endcase
    hit        = inside_i && (value != '0) && (alpha != '0);
    alpha_prod = BLEND_W'(weight_i) * BLEND_W'(alpha);
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      val_q <= value;
      a_q   <= alpha_prod[BLEND_W-1:PIX_W];
      smp_q <= sample_i;
      hit_q <= hit;
    end
  end

  // Stage 3: weighted sum of logo value and sample.
  assign blend_sum = BLEND_W'(val_q) * BLEND_W'(a_q) +
                     BLEND_W'(smp_q) * BLEND_W'(ALPHA_MAX - a_q);

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      out_q     <= hit_q ? blend_sum[BLEND_W-1:PIX_W] : smp_q;
      blended_q <= hit_q;
    end
  end

  assign sample_o  = out_q;
  assign blended_o = blended_q;

endmodule

// ----- hdl/yuv420_logo_alpha_overlay.sv -----
// Top level of the YUV 4:2:0 logo overlay with its pipeline control.
//
//   Channel  Direction  Handshake                    Payload
//   s_axis   in         s_axis_tvalid_i / tready_o   tdata: column, row, sample, values, alpha
//                                                     tuser: operation, plane
//   m_axis   out        m_axis_tvalid_o / tready_i   tdata: sample_out; tuser: blended
//   cfg      in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One transaction is taken every clock while s_axis_tready_o is high. A video
// transaction passes the input register, logo memory read, alpha scaling
// multiply and blend multiply-add into the output register that drives m_axis.
// Load transactions write the logo memories from the input stage and give no
// result. Reset restores the register defaults; the logo memories are not
// cleared. A full stage holds only while its successor stalls, so bubbles close
// up and a stall on m_axis reaches s_axis_tready_o only once all stages are full.
`timescale 1ns / 1ps

module yuv420_logo_alpha_overlay
  import yuvlogo_pkg::*;
#(
  parameter int MAX_LOGO_W = 64,
  parameter int MAX_LOGO_H = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [11:0] column, [23:12] row, [31:24] sample, [39:32] logo_value,
  // [47:40] logo_value_v, [55:48] logo_alpha
  input  logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] operation, [3:2] plane
  input  logic [S_TUSER_W-1:0]  s_axis_tuser_i,
  // Output stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [7:0] sample_out
  output logic [M_TDATA_W-1:0]  m_axis_tdata_o,
  // [0] blended
  output logic [0:0]            m_axis_tuser_o,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Store geometry. Entries are addressed as {row, column}.
  localparam int CHROMA_W = (MAX_LOGO_W + 1) / 2;
  localparam int CHROMA_H = (MAX_LOGO_H + 1) / 2;
  localparam int LX_W     = $clog2(MAX_LOGO_W);
  localparam int LY_W     = $clog2(MAX_LOGO_H);
  localparam int CX_W     = (CHROMA_W > 1) ? $clog2(CHROMA_W) : 1;
  localparam int CY_W     = (CHROMA_H > 1) ? $clog2(CHROMA_H) : 1;

  // Stage enables: a stage loads when it is empty or its successor moves on.
  logic en1, en2, en3, en4;

  // Stage 1: registered input transaction.
  logic             v1_d, v1_q;
  op_e              op1_q;
  plane_e           plane1_q;
  logic [POS_W-1:0] col1_q, row1_q;
  logic [PIX_W-1:0] smp1_q, val1_q, valv1_q, alp1_q;

  // Stage 2: memory read in flight.
  logic             v2_d, v2_q;
  plane_e           plane2_q;
  logic             inside2_q;
  logic [PIX_W-1:0] smp2_q;

  // Stages 3 and 4 carry only valid bits here; data lives in the mix unit.
  logic v3_d, v3_q, v4_d, v4_q;

  win_cfg_t            win;
  logic [WEIGHT_W-1:0] weight_sat;

  logic             inside1;
  logic [POS_W-1:0] logo_col1, logo_row1;
  store_ctl_t       store_ctl;
  logic             luma_load_ok, chroma_load_ok;
  logic [2*PIX_W-1:0] luma_word;
  logic [3*PIX_W-1:0] chroma_word;

  assign cfg_ready_o = 1'b1;

  yuvlogo_cfg #(
    .MAX_LOGO_W (MAX_LOGO_W),
    .MAX_LOGO_H (MAX_LOGO_H)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .win_o      (win),
    .weight_o   (weight_sat)
  );

  // Handshake chain from the output back to the input.
  always_comb begin
    en4 = !v4_q || m_axis_tready_i;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign s_axis_tready_o = en1;

  always_comb begin
    v1_d = en1 ? s_axis_tvalid_i : v1_q;
    v2_d = en2 ? (v1_q && (op1_q == OP_VIDEO)) : v2_q;
    v3_d = en3 ? v2_q : v3_q;
    v4_d = en4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s_axis_tvalid_i) begin
      op1_q    <= op_e'(s_axis_tuser_i[1:0]);
      plane1_q <= plane_e'(s_axis_tuser_i[3:2]);
      col1_q   <= s_axis_tdata_i[11:0];
      row1_q   <= s_axis_tdata_i[23:12];
      smp1_q   <= s_axis_tdata_i[31:24];
      val1_q   <= s_axis_tdata_i[39:32];
      valv1_q  <= s_axis_tdata_i[47:40];
      alp1_q   <= s_axis_tdata_i[55:48];
    end
  end

  yuvlogo_window u_window (
    .win_i      (win),
    .plane_i    (plane1_q),
    .column_i   (col1_q),
    .row_i      (row1_q),
    .inside_o   (inside1),
    .logo_col_o (logo_col1),
    .logo_row_o (logo_row1)
  );

  // Loads write as they leave stage 1, in order with the reads of video
  // transactions, so a later sample always sees an earlier load.
  always_comb begin
    luma_load_ok   = (col1_q < POS_W'(MAX_LOGO_W)) && (row1_q < POS_W'(MAX_LOGO_H));
    chroma_load_ok = (col1_q < POS_W'(CHROMA_W)) && (row1_q < POS_W'(CHROMA_H));
    store_ctl.luma_we   = v1_q && en2 && (op1_q == OP_LOAD_LUMA) && luma_load_ok;
    store_ctl.chroma_we = v1_q && en2 && (op1_q == OP_LOAD_CHROMA) && chroma_load_ok;
    store_ctl.rd_en     = en2;
  end

  yuvlogo_store #(
    .LX_W (LX_W),
    .LY_W (LY_W),
    .CX_W (CX_W),
    .CY_W (CY_W)
  ) u_store (
    .clk_i          (clk_i),
    .ctl_i          (store_ctl),
    .luma_waddr_i   ({row1_q[LY_W-1:0], col1_q[LX_W-1:0]}),
    .chroma_waddr_i ({row1_q[CY_W-1:0], col1_q[CX_W-1:0]}),
    .value_i        (val1_q),
    .value_v_i      (valv1_q),
    .alpha_i        (alp1_q),
    .luma_raddr_i   ({logo_row1[LY_W-1:0], logo_col1[LX_W-1:0]}),
    .chroma_raddr_i ({logo_row1[CY_W-1:0], logo_col1[CX_W-1:0]}),
    .luma_rdata_o   (luma_word),
    .chroma_rdata_o (chroma_word)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      plane2_q  <= plane1_q;
      inside2_q <= inside1;
      smp2_q    <= smp1_q;
    end
  end

  yuvlogo_mix u_mix (
    .clk_i         (clk_i),
    .en3_i         (en3),
    .en4_i         (en4),
    .plane_i       (plane2_q),
    .inside_i      (inside2_q),
    .sample_i      (smp2_q),
    .luma_word_i   (luma_word),
    .chroma_word_i (chroma_word),
    .weight_i      (weight_sat),
    .sample_o      (m_axis_tdata_o),
    .blended_o     (m_axis_tuser_o[0])
  );

  assign m_axis_tvalid_o = v4_q;

  // A load leaving stage 1 never turns into a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2 && (op1_q != OP_VIDEO)) |=> !v2_q)
    else $error("load transaction entered the result pipeline");

  // A stalled stage 2 keeps its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(smp2_q) && $stable(inside2_q)))
    else $error("stage 2 lost its transaction during a stall");

  // With nothing behind it, a delivered result is not shown again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && m_axis_tready_i && !v3_q) |=> !v4_q)
    else $error("result repeated after delivery");

  // Only samples of a real plane can fall inside the logo window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && inside2_q) |-> (plane2_q == PLANE_Y || plane2_q == PLANE_U ||
                             plane2_q == PLANE_V))
    else $error("window hit on an invalid plane");

endmodule
